/* rtl/udpc_pkg.sv */
package udpc_pkg;

    // Checksum arithmetic
    localparam logic [15:0] UDP_PROTOCOL   = 16'h0011;
    localparam logic [15:0] POS_MAX        = 16'hFFFF;
    localparam int unsigned OFFSET_W       = 10;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 10'd18;

    // Byte indexes relative to the IPv4 header / UDP header
    localparam logic [15:0] IP_ADDR_START  = 16'd12;
    localparam logic [15:0] UDP_START      = 16'd20;
    localparam logic [15:0] UDP_LEN_NEXT   = 16'd19;  // UDP byte index plus one
    localparam logic [15:0] UDP_HDR_SUMMED = 16'd6;
    localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;
    localparam logic [15:0] UDP_LEN_LOW    = 16'd5;

    // Register indexes of the configuration port
    localparam logic REG_IP_OFFSET = 1'b0;

    // Result of one frame
    typedef struct packed {
        logic [15:0] checksum;
        logic [15:0] udp_length;
        logic        short_frame;
    } result_t;

    // One's-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] t;
        begin
            s = {1'b0, a} + {1'b0, b};
            t = {1'b0, s[15:0]} + {16'd0, s[16]};
            oc_add = t[15:0];
        end
    endfunction

endpackage

/* rtl/udpc_sum.sv */
module udpc_sum
    import udpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                frame_last,
    input  logic [OFFSET_W-1:0] ip_header_offset,
    output result_t             result
);

    logic [15:0] pos_reg,  pos_next;
    logic [15:0] sum_reg,  sum_next;
    logic [7:0]  high_reg, high_next;
    logic [15:0] len_reg,  len_next;
    logic        done_reg, done_next;

    logic [15:0] rel;      // byte index within the IPv4 header onward
    logic [15:0] u;        // byte index within the UDP segment
    logic [15:0] u1;       // u + 1
    logic [15:0] w;        // assembled big-endian word
    logic [15:0] s1;
    logic [15:0] s2;
    logic        live;

    assign rel  = pos_reg - {{(16-OFFSET_W){1'b0}}, ip_header_offset};
    assign u    = rel - UDP_START;
    assign u1   = rel - UDP_LEN_NEXT;
    assign w    = {high_reg, data_byte};
    assign live = (pos_reg != POS_MAX) && !done_reg &&
                  (pos_reg >= {{(16-OFFSET_W){1'b0}}, ip_header_offset}) &&
                  (rel >= IP_ADDR_START);

    // Word with the length field is also counted in the pseudo-header
    assign s1 = oc_add(sum_reg, w);
    assign s2 = oc_add(oc_add(s1, w), UDP_PROTOCOL);

    // Per-byte state update
    always_comb
    begin
        sum_next  = sum_reg;
        high_next = high_reg;
        len_next  = len_reg;
        done_next = done_reg;
        pos_next  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 16'd1;
        if (live)
        begin
            if (rel < UDP_START)
            begin
                // source and destination addresses
                if (!rel[0])
                    high_next = data_byte;
                else
                    sum_next = s1;
            end
            else if (u < UDP_HDR_SUMMED)
            begin
                // ports and length
                if (!u[0])
                    high_next = data_byte;
                else if (u == UDP_LEN_LOW)
                begin
                    len_next = w;
                    sum_next = s2;
                    if (w <= UDP_HDR_SUMMED)
                        done_next = 1'b1;
                end
                else
                    sum_next = s1;
            end
            else if (u < UDP_HDR_BYTES)
            begin
                // checksum word: skipped
                if (u1 == len_reg)
                    done_next = 1'b1;
            end
            else if (!u[0])
            begin
                if (u1 == len_reg)
                begin
                    // odd final byte, padded with zero
                    sum_next  = oc_add(sum_reg, {data_byte, 8'h00});
                    done_next = 1'b1;
                end
                else
                    high_next = data_byte;
            end
            else
            begin
                sum_next = s1;
                if (u1 == len_reg)
                    done_next = 1'b1;
            end
        end
    end

    assign result.checksum    = ~sum_next;
    assign result.udp_length  = len_next;
    assign result.short_frame = !done_next;

    // State registers, cleared after each frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            high_reg <= '0;
            len_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (step)
        begin
            if (frame_last)
            begin
                pos_reg  <= '0;
                sum_reg  <= '0;
                high_reg <= '0;
                len_reg  <= '0;
                done_reg <= 1'b0;
            end
            else
            begin
                pos_reg  <= pos_next;
                sum_reg  <= sum_next;
                high_reg <= high_next;
                len_reg  <= len_next;
                done_reg <= done_next;
            end
        end
    end

endmodule

/* rtl/udp_checksum_from_frame.sv */
// Channel   Dir  Handshake                     Contents
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: data_byte; tlast: frame_last
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: checksum, udp_length; tuser: short_frame
// apb       in   psel/penable/pwrite/pready    reg 0 at 0x0: ip_header_offset
//
// One byte per clock sustained, save when input stops as described below. A byte
// is registered on entry and summed from the input register by end-around-carry
// adders; the result of a frame enters the output register as its last byte is summed.
// Reset clears the frame state and sets ip_header_offset to 18. Only a stalled
// output holding a result, with the next frame's last byte waiting, stops input.
module udp_checksum_from_frame
    import udpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // frame_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] checksum, [31:16] udp_length
    output logic        m_axis_tuser,   // short_frame
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [OFFSET_W-1:0] offset_reg;
    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;
    logic                out_valid_reg;
    result_t             out_reg;
    result_t             result;
    logic                out_free;
    logic                advance;
    logic                cfg_write;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_IP_OFFSET) ?
                       {{(32-OFFSET_W){1'b0}}, offset_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= OFFSET_RESET;
        else if (cfg_write && (paddr[2] == REG_IP_OFFSET))
            offset_reg <= pwdata[OFFSET_W-1:0];
    end

    // Flow control: a last byte moves on only when the output register can take it
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Checksum datapath
    udpc_sum u_sum (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .data_byte        (in_byte_reg),
        .frame_last       (in_last_reg),
        .ip_header_offset (offset_reg),
        .result           (result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.udp_length, out_reg.checksum};
    assign m_axis_tuser  = out_reg.short_frame;

    // A result only appears after a last byte was summed
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(advance && in_last_reg))
        else $error("result without a last byte");

    // Input stalls only behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && in_last_reg && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without cause");

    // Offset register takes the written value
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && (paddr[2] == REG_IP_OFFSET)) |=>
        (offset_reg == $past(pwdata[OFFSET_W-1:0])))
        else $error("offset write lost");

endmodule

/* tb/tb_udp_checksum_from_frame.sv */
`timescale 1ns / 1ps

import udpc_pkg::*;

// Tracks the checksum state of the frame in flight and holds the results owed by the DUT
class udp_checksum_tracker;
    logic [9:0]  hdr_offset;
    logic [15:0] pos;
    logic [15:0] sum;
    logic [7:0]  hi_byte;
    logic [15:0] len_field;
    bit          seg_done;
    result_t     owed_results[$];
    int          errors;

    function new();
        hdr_offset = OFFSET_RESET;
        errors = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        pos = '0;
        sum = '0;
        hi_byte = '0;
        len_field = '0;
        seg_done = 1'b0;
    endfunction

    // 16-bit add, carry out folded back into bit 0
    function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // Fold one frame byte into the running sum
    function void absorb(logic [7:0] b);
        int r;
        int u;
        logic [15:0] w;
        if (pos == POS_MAX || seg_done || pos < {6'd0, hdr_offset})
            return;
        r = int'(pos) - int'(hdr_offset);
        if (r < int'(IP_ADDR_START))
            return;
        // source and destination addresses
        if (r < int'(UDP_START)) begin
            if (r % 2 == 0)
                hi_byte = b;
            else
                sum = ones_add(sum, {hi_byte, b});
            return;
        end
        u = r - int'(UDP_START);
        // ports and length; length also goes into the pseudo-header
        if (u < int'(UDP_HDR_SUMMED)) begin
            if (u % 2 == 0) begin
                hi_byte = b;
                return;
            end
            w = {hi_byte, b};
            sum = ones_add(sum, w);
            if (u == int'(UDP_LEN_LOW)) begin
                len_field = w;
                sum = ones_add(sum, w);
                sum = ones_add(sum, UDP_PROTOCOL);
                if (w <= UDP_HDR_SUMMED)
                    seg_done = 1'b1;
            end
            return;
        end
        // checksum word is skipped
        if (u < int'(UDP_HDR_BYTES)) begin
            if (u + 1 == int'(len_field))
                seg_done = 1'b1;
            return;
        end
        // payload; odd tail byte padded with zero
        if (u % 2 == 0) begin
            if (u + 1 == int'(len_field)) begin
                sum = ones_add(sum, {b, 8'h00});
                seg_done = 1'b1;
            end
            else begin
                hi_byte = b;
            end
            return;
        end
        sum = ones_add(sum, {hi_byte, b});
        if (u + 1 == int'(len_field))
            seg_done = 1'b1;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
        result_t r;
        absorb(b);
        if (pos != POS_MAX)
            pos = pos + 16'd1;
        if (last) begin
            r.checksum = ~sum;
            r.udp_length = len_field;
            r.short_frame = !seg_done;
            owed_results.push_back(r);
            clear_frame();
        end
    endfunction

    function void check_result(result_t got);
        result_t exp_r;
        if (owed_results.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: unexpected result csum=%h len=%h short=%b",
                         got.checksum, got.udp_length, got.short_frame);
            return;
        end
        exp_r = owed_results.pop_front();
        if (got.checksum !== exp_r.checksum || got.udp_length !== exp_r.udp_length ||
            got.short_frame !== exp_r.short_frame) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: csum exp %h got %h, len exp %h got %h, short exp %b got %b",
                         exp_r.checksum, got.checksum, exp_r.udp_length, got.udp_length,
                         exp_r.short_frame, got.short_frame);
        end
    endfunction
endclass

module tb_udp_checksum_from_frame;

    localparam int CYCLE_LIMIT = 400000;
    localparam int FILL_RANDOM = -1;
    localparam int DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tlast;   // frame_last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [15:0] checksum, [31:16] udp_length
    logic        m_axis_tuser;   // short_frame
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    udp_checksum_tracker tracker;
    logic [7:0]  frame_bytes[$];
    logic [9:0]  hdr_ofs = OFFSET_RESET;
    int          src_idle_pct;
    int          sink_idle_pct;
    int          cycle_count = 0;
    result_t     seen_result;

    udp_checksum_from_frame dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 clk = ~clk;

    // Receiver backpressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Watch both streams; input words feed the tracker, output words get checked
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                seen_result.checksum = m_axis_tdata[15:0];
                seen_result.udp_length = m_axis_tdata[31:16];
                seen_result.short_frame = m_axis_tuser;
                tracker.check_result(seen_result);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Frame of total bytes; UDP length field placed after the header if it fits
    function automatic void build_frame(int ofs, logic [15:0] ulen, int total, int fill);
        frame_bytes.delete();
        for (int i = 0; i < total; i++)
            frame_bytes.push_back(fill < 0 ? 8'($urandom_range(255)) : 8'(fill));
        if (ofs + 24 < total)
            frame_bytes[ofs + 24] = ulen[15:8];
        if (ofs + 25 < total)
            frame_bytes[ofs + 25] = ulen[7:0];
    endfunction

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++) begin
            while ($urandom_range(99) < src_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= frame_bytes[i];
            s_axis_tlast <= (i == frame_bytes.size() - 1);
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
        end
    endtask

    // Waits on the clock first so the last accepted word is already in the tracker
    task automatic wait_drained();
        @(posedge clk);
        while (tracker.owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write of the header offset, only once the stream has drained
    task automatic write_offset(logic [9:0] v);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_IP_OFFSET, 2'b00};
        pwdata <= {22'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tracker.hdr_offset = v;
        hdr_ofs = v;
    endtask

    // Mostly well-formed frames, some truncated, some with wild lengths, some noise
    task automatic random_frame();
        int ofs;
        int kind;
        int full;
        int total;
        logic [15:0] ulen;
        ofs = int'(hdr_ofs);
        kind = $urandom_range(99);
        if (kind < 12) begin
            ulen = 16'($urandom);
            total = $urandom_range(1, 50);
        end
        else if (kind < 20) begin
            ulen = 16'($urandom);
            total = ofs + 26 + $urandom_range(0, 30);
        end
        else begin
            ulen = (kind < 30) ? 16'($urandom_range(29, 80)) : 16'($urandom_range(0, 28));
            full = ofs + 20 + int'(ulen);
            if (full < ofs + 26)
                full = ofs + 26;
            total = (kind < 35) ? $urandom_range(1, full) : full + $urandom_range(0, 3);
        end
        build_frame(ofs, ulen, total, FILL_RANDOM);
        send_frame();
    endtask

    task automatic random_phase(int src_pct, int sink_pct, logic [9:0] ofs);
        int n_bytes;
        int n_frames;
        n_bytes = 0;
        n_frames = 0;
        write_offset(ofs);
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        while (n_bytes < 140 || n_frames < 3) begin
            random_frame();
            n_bytes += frame_bytes.size();
            n_frames++;
        end
    endtask

    initial
    begin
        int o;
        tracker = new();
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tlast <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        src_idle_pct = 14;
        sink_idle_pct = 51;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at the reset offset
        o = int'(hdr_ofs);
        // header-only segment, all ones then all zeros
        build_frame(o, 16'd8, o + 28, 8'hFF);
        send_frame();
        build_frame(o, 16'd8, o + 28, 8'h00);
        send_frame();
        // odd lengths, tail padded with zero
        build_frame(o, 16'd13, o + 33, FILL_RANDOM);
        send_frame();
        build_frame(o, 16'd9, o + 29, 8'hFF);
        send_frame();
        // lengths below eight
        build_frame(o, 16'd0, o + 26, FILL_RANDOM);
        send_frame();
        build_frame(o, 16'd6, o + 26, FILL_RANDOM);
        send_frame();
        build_frame(o, 16'd7, o + 27, FILL_RANDOM);
        send_frame();
        // trailing bytes after the segment
        build_frame(o, 16'd10, o + 42, FILL_RANDOM);
        send_frame();
        // frame ends inside the payload, then before the length is seen
        build_frame(o, 16'd30, o + 32, FILL_RANDOM);
        send_frame();
        build_frame(o, 16'd20, o + 12, FILL_RANDOM);
        send_frame();
        // one-byte frame
        build_frame(o, 16'd0, 1, FILL_RANDOM);
        send_frame();
        // largest length field
        build_frame(o, 16'hFFFF, o + 60, FILL_RANDOM);
        send_frame();
        // sum comes to all ones, so the checksum is zero
        build_frame(o, 16'd10, o + 30, 8'h00);
        frame_bytes[o + 28] = 8'hFF;
        frame_bytes[o + 29] = 8'hDA;
        send_frame();

        // Random traffic under three idle profiles
        random_phase(14, 51, 10'd0);
        random_phase(51, 14, 10'($urandom_range(1, 12)));
        random_phase(0, 0, 10'($urandom_range(0, 6)));

        // Largest header offset; the frame ends long before the header
        write_offset(10'd1023);
        build_frame(1023, 16'd9, 40, FILL_RANDOM);
        send_frame();
        s_axis_tvalid <= 1'b0;

        wait_drained();
        if (tracker.errors == 0 && tracker.owed_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
rtl/udpc_pkg.sv
rtl/udpc_sum.sv
rtl/udp_checksum_from_frame.sv
tb/tb_udp_checksum_from_frame.sv
